@@ src/life_pkg.sv @@
// Shared constants and codes for the life automaton generation block.
package life_pkg;

   localparam int GRID_WIDTH  = 16;
   localparam int GRID_HEIGHT = 32;

   // Row counter and row address width
   localparam int ROW_W = $clog2(GRID_HEIGHT);

   // Fixed field widths of the ports
   localparam int IDX_FIELD_W  = 5;
   localparam int CELL_FIELD_W = 16;

   // Function codes carried on req_func
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef logic [GRID_WIDTH-1:0] row_type;

endpackage

@@ src/life_row_rule.sv @@
// B3/S23 rule applied to a whole row from a three-row window.
module life_row_rule (
   input  life_pkg::row_type above_row,
   input  life_pkg::row_type center_row,
   input  life_pkg::row_type below_row,
   output life_pkg::row_type next_row
);

   // One dead column on each side so the edges see no neighbors
   logic [life_pkg::GRID_WIDTH+1:0] above_pad;
   logic [life_pkg::GRID_WIDTH+1:0] center_pad;
   logic [life_pkg::GRID_WIDTH+1:0] below_pad;
   logic [3:0]                      count [life_pkg::GRID_WIDTH];

   assign above_pad  = {1'b0, above_row, 1'b0};
   assign center_pad = {1'b0, center_row, 1'b0};
   assign below_pad  = {1'b0, below_row, 1'b0};

   always_comb begin
      for (int c = 0; c < life_pkg::GRID_WIDTH; c++) begin
         count[c] = 4'(above_pad[c]) + 4'(above_pad[c+1]) + 4'(above_pad[c+2])
                  + 4'(center_pad[c]) + 4'(center_pad[c+2])
                  + 4'(below_pad[c]) + 4'(below_pad[c+1]) + 4'(below_pad[c+2]);
         next_row[c] = (count[c] == 4'd3) || (center_row[c] && (count[c] == 4'd2));
      end
   end

endmodule

@@ src/life_automaton_generation.sv @@
// Top level: row store, generation sweep sequencer and response register.
// A write word leaves the block idle, so it is ready again on the next cycle.
// A step word is followed by a sweep: a read in idle and the fill state load the row
// window, then one row per cycle through the shared row rule unit, paced by rsp_stall;
// the block is ready again once the bottom row has left the row rule unit.
// Reset is synchronous: per-row valid bits clear, so the grid reads dead.
module life_automaton_generation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [life_pkg::IDX_FIELD_W-1:0]    req_row_index,
   input  logic [life_pkg::CELL_FIELD_W-1:0]   req_row_cells,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [life_pkg::IDX_FIELD_W-1:0]    rsp_out_row_index,
   output logic [life_pkg::CELL_FIELD_W-1:0]   rsp_out_row_cells,
   output logic                                rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_RUN
   } state_type;

   state_type                   state_ff;
   logic [life_pkg::ROW_W-1:0]  row_ff;
   life_pkg::row_type           prev_ff;
   life_pkg::row_type           cur_ff;
   life_pkg::row_type           rd_q_ff;
   logic                        rsp_valid_ff;
   logic [life_pkg::ROW_W-1:0]  out_row_ff;
   life_pkg::row_type           out_cells_ff;
   logic                        last_ff;

   life_pkg::row_type           mem [life_pkg::GRID_HEIGHT];
   logic [life_pkg::GRID_HEIGHT-1:0] row_vld_ff;

   logic                        req_acc;
   logic                        advance;
   logic                        row_last;
   life_pkg::row_type           below_row;
   life_pkg::row_type           new_row;
   logic                        rd_en;
   logic [life_pkg::ROW_W:0]    rd_addr_wide;
   logic [life_pkg::ROW_W-1:0]  rd_addr;
   logic                        mem_we;
   logic [life_pkg::ROW_W-1:0]  wr_addr;
   life_pkg::row_type           wr_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && (state_ff == ST_IDLE);
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign row_last  = (row_ff == life_pkg::ROW_W'(life_pkg::GRID_HEIGHT - 1));
   // Below the bottom edge everything is dead
   assign below_row = row_last ? '0 : rd_q_ff;
   assign rd_addr   = rd_addr_wide[life_pkg::ROW_W-1:0];

   life_row_rule u_rule (
      .above_row  (prev_ff),
      .center_row (cur_ff),
      .below_row  (below_row),
      .next_row   (new_row)
   );

   // Read runs two rows ahead of the row being computed; the new row is
   // written back in place since its old value already sits in the window.
   always_comb begin
      rd_en        = 1'b0;
      rd_addr_wide = '0;
      mem_we       = 1'b0;
      wr_addr      = life_pkg::ROW_W'(req_row_index);
      wr_data      = life_pkg::GRID_WIDTH'(req_row_cells);
      case (state_ff)
         ST_IDLE: begin
            rd_en  = req_acc && (req_func == life_pkg::FUNC_STEP);
            mem_we = req_acc && (req_func == life_pkg::FUNC_WRITE)
                     && (int'(req_row_index) < life_pkg::GRID_HEIGHT);
         end
         ST_FILL: begin
            rd_en        = 1'b1;
            rd_addr_wide = (life_pkg::ROW_W+1)'(1);
         end
         ST_RUN: begin
            rd_addr_wide = {1'b0, row_ff} + (life_pkg::ROW_W+1)'(2);
            rd_en        = advance
                           && (rd_addr_wide < (life_pkg::ROW_W+1)'(life_pkg::GRID_HEIGHT));
            mem_we       = advance;
            wr_addr      = row_ff;
            wr_data      = new_row;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= row_vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (mem_we) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_RUN) && advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && (req_func == life_pkg::FUNC_STEP)) begin
                  state_ff <= ST_FILL;
               end
            end
            ST_FILL: begin
               prev_ff  <= '0;
               cur_ff   <= rd_q_ff;
               row_ff   <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (advance) begin
                  out_row_ff   <= row_ff;
                  out_cells_ff <= new_row;
                  last_ff      <= row_last;
                  prev_ff      <= cur_ff;
                  cur_ff       <= below_row;
                  if (row_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff <= row_ff + life_pkg::ROW_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row_index = life_pkg::IDX_FIELD_W'(out_row_ff);
   assign rsp_out_row_cells = life_pkg::CELL_FIELD_W'(out_cells_ff);
   assign rsp_last          = last_ff;

   // Read-ahead and write-back never hit the same row in the same cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en) |-> (wr_addr != rd_addr))
      else $error("row store read and write collide");

   // Sweep ends right after the bottom row is loaded
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && advance && row_last) |=> (state_ff == ST_IDLE))
      else $error("sweep did not end after bottom row");

   // Last marker goes with the bottom row only
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (last_ff == (out_row_ff == life_pkg::ROW_W'(life_pkg::GRID_HEIGHT - 1))))
      else $error("last marker on wrong row");

   // Rows of one generation leave in order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !last_ff) |=>
         (!rsp_valid_ff || (out_row_ff == $past(out_row_ff) + life_pkg::ROW_W'(1))))
      else $error("rows out of order");

endmodule

@@ dv/life_checker.sv @@
`timescale 1ns / 1ps
// Checker for the life grid block: tracks the grid, predicts each generation, compares rows.
module life_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_func,
   input  logic [life_pkg::IDX_FIELD_W-1:0]  req_row_index,
   input  logic [life_pkg::CELL_FIELD_W-1:0] req_row_cells,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [life_pkg::IDX_FIELD_W-1:0]  rsp_out_row_index,
   input  logic [life_pkg::CELL_FIELD_W-1:0] rsp_out_row_cells,
   input  logic                              rsp_last,
   output int                                fail_count,
   output int                                pending_rows,
   output int                                steps_seen,
   output int                                rows_checked
);

   localparam int STAY_MIN    = 2;
   localparam int BIRTH_COUNT = 3;

   typedef struct packed {
      logic [life_pkg::IDX_FIELD_W-1:0]  idx;
      logic [life_pkg::CELL_FIELD_W-1:0] cells;
      logic                              last;
   } gen_row_type;

   life_pkg::row_type grid      [life_pkg::GRID_HEIGHT];
   life_pkg::row_type prev_grid [life_pkg::GRID_HEIGHT];
   gen_row_type       expected_rows [$];

   // cells off the board read as dead
   function automatic int prev_cell(int r, int c);
      if (r < 0 || r >= life_pkg::GRID_HEIGHT || c < 0 || c >= life_pkg::GRID_WIDTH)
         return 0;
      return int'(prev_grid[r][c]);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      fail_count++;
   endtask

   task automatic next_generation();
      int                n;
      bit                alive;
      life_pkg::row_type fresh;
      prev_grid = grid;
      for (int r = 0; r < life_pkg::GRID_HEIGHT; r++) begin
         fresh = '0;
         for (int c = 0; c < life_pkg::GRID_WIDTH; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0) n += prev_cell(r + dr, c + dc);
            alive = prev_grid[r][c];
            if (alive ? (n == STAY_MIN || n == BIRTH_COUNT) : (n == BIRTH_COUNT))
               fresh[c] = 1'b1;
         end
         grid[r] = fresh;
         expected_rows.push_back('{idx: life_pkg::IDX_FIELD_W'(r),
                                   cells: life_pkg::CELL_FIELD_W'(fresh),
                                   last: (r == life_pkg::GRID_HEIGHT - 1)});
      end
   endtask

   task automatic check_row();
      gen_row_type want;
      if (expected_rows.size() == 0) begin
         report_mismatch($sformatf("row word %0d arrived with no step pending",
                                   rsp_out_row_index));
         return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (rsp_out_row_index !== want.idx)
         report_mismatch($sformatf("row index got %0d expected %0d",
                                   rsp_out_row_index, want.idx));
      if (rsp_out_row_cells !== want.cells)
         report_mismatch($sformatf("row %0d cells got %04h expected %04h",
                                   want.idx, rsp_out_row_cells, want.cells));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("row %0d last got %b expected %b",
                                   want.idx, rsp_last, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (grid[r]) grid[r] = '0;
         expected_rows.delete();
         steps_seen   = 0;
         rows_checked = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_row();
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            if (req_func == life_pkg::FUNC_WRITE) begin
               if (req_row_index < life_pkg::GRID_HEIGHT)
                  grid[req_row_index] = life_pkg::row_type'(req_row_cells);
            end else begin
               next_generation();
               steps_seen++;
            end
         end
      end
      pending_rows = expected_rows.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the life grid block: stimulus, receiver back-pressure and verdict.
module tb_top;

   localparam int ITEM_TARGET  = 350;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_func;
   logic [life_pkg::IDX_FIELD_W-1:0]  req_row_index;
   logic [life_pkg::CELL_FIELD_W-1:0] req_row_cells;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [life_pkg::IDX_FIELD_W-1:0]  rsp_out_row_index;
   logic [life_pkg::CELL_FIELD_W-1:0] rsp_out_row_cells;
   logic                              rsp_last;

   int fail_count;
   int pending_rows;
   int steps_seen;
   int rows_checked;
   int items_sent;
   int writes_sent;
   bit no_gaps;
   bit rsp_quiet;
   bit hold_rsp;

   life_automaton_generation u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_row_cells     (req_row_cells),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row_index (rsp_out_row_index),
      .rsp_out_row_cells (rsp_out_row_cells),
      .rsp_last          (rsp_last)
   );

   life_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_row_cells     (req_row_cells),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row_index (rsp_out_row_index),
      .rsp_out_row_cells (rsp_out_row_cells),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_rows      (pending_rows),
      .steps_seen        (steps_seen),
      .rows_checked      (rows_checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [life_pkg::CELL_FIELD_W-1:0] pick_cells();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return '1;
         2: return life_pkg::CELL_FIELD_W'($urandom & $urandom);
         3: return life_pkg::CELL_FIELD_W'(16'h0007 << $urandom_range(0, 13));
         default: return life_pkg::CELL_FIELD_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic func, input logic [life_pkg::IDX_FIELD_W-1:0] idx,
                            input logic [life_pkg::CELL_FIELD_W-1:0] cells);
      int g;
      req_func      <= func;
      req_row_index <= idx;
      req_row_cells <= cells;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      g = no_gaps ? 0 : pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic write_row(input int idx, input logic [life_pkg::CELL_FIELD_W-1:0] cells);
      send_word(life_pkg::FUNC_WRITE, life_pkg::IDX_FIELD_W'(idx), cells);
      writes_sent++;
   endtask

   // index and cell fields are don't-care on a step, so fill them with noise
   task automatic step_grid();
      send_word(life_pkg::FUNC_STEP, life_pkg::IDX_FIELD_W'($urandom),
                life_pkg::CELL_FIELD_W'($urandom));
   endtask

   // receiver: random stalls, quiet stretches, and one long hold-off on request
   initial begin
      int g;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_stall <= 1'b1;
               repeat (g) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int nwrites;
      int nsteps;
      int base;
      int phase;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = life_pkg::FUNC_WRITE;
      req_row_index = '0;
      req_row_cells = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty board stays empty
      step_grid();
      // full rows along both edges plus corner cells
      write_row(0, 16'hFFFF);
      write_row(1, 16'hFFFF);
      write_row(life_pkg::GRID_HEIGHT - 1, 16'hFFFF);
      write_row(life_pkg::GRID_HEIGHT - 2, 16'h8001);
      step_grid();
      // blinker mid-board, two generations
      write_row(15, 16'h0070);
      step_grid();
      step_grid();
      // vertical blinkers hugging the left and right columns
      write_row(10, 16'h8001);
      write_row(11, 16'h8001);
      write_row(12, 16'h8001);
      step_grid();
      write_row(0, 16'h5555);
      write_row(life_pkg::GRID_HEIGHT - 1, 16'hAAAA);
      step_grid();
      // glider
      write_row(2, 16'h0002);
      write_row(3, 16'h0004);
      write_row(4, 16'h0007);
      step_grid();
      step_grid();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         if (phase % 6 == 0) begin
            no_gaps   = ($urandom_range(0, 2) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         if (phase == 12) begin
            // long receiver hold-off with the sender pushing words back to back
            no_gaps  = 1'b1;
            hold_rsp = 1'b1;
            step_grid();
            write_row($urandom_range(0, life_pkg::GRID_HEIGHT - 1), pick_cells());
            step_grid();
            step_grid();
            no_gaps = 1'b0;
         end
         // a band of mostly adjacent rows, then up to three generations
         nwrites = $urandom_range(0, 8);
         base    = $urandom_range(0, life_pkg::GRID_HEIGHT - 1);
         for (int k = 0; k < nwrites; k++) begin
            if ($urandom_range(0, 4) == 0)
               write_row($urandom_range(0, life_pkg::GRID_HEIGHT - 1), pick_cells());
            else
               write_row((base + k) % life_pkg::GRID_HEIGHT, pick_cells());
         end
         nsteps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 1;
         for (int k = 0; k < nsteps; k++) step_grid();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_rows == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d words: %0d row writes, %0d generation steps, %0d rows checked.",
               items_sent, writes_sent, steps_seen, rows_checked);
      $display("Covered edge and corner patterns, random stalls and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (fail_count == 0 && pending_rows == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
